FILE: src/gss_pkg.sv
// Package for the glyph scaler with character rounding.
// Holds the widths, the default glyph height and the shared payload types.
// No dependencies.
`default_nettype none

package gss_pkg;

  localparam int unsigned RowWidth         = 6;
  localparam int unsigned LineWidth        = 16;
  localparam int unsigned RowIndexWidth    = 4;
  localparam int unsigned GlyphRowsDefault = 10;

  typedef logic [RowWidth-1:0]      row_t;
  typedef logic [LineWidth-1:0]     line_t;
  typedef logic [RowIndexWidth-1:0] row_index_t;

  // Pair of scaled lines built from one source row.
  typedef struct packed {
    line_t upper;
    line_t lower;
  } lines_t;

  // One result transaction.
  typedef struct packed {
    line_t upper_line;
    line_t lower_line;
    logic  glyph_done;
  } result_t;

endpackage

`default_nettype wire

FILE: src/gss_if.sv
// Channel interfaces of the glyph scaler: source rows in, scaled line pairs out.
// Depends on gss_pkg.
`default_nettype none

interface gss_in_if;
  logic          valid;
  logic          ready;
  gss_pkg::row_t glyph_row;

  modport source (output valid, output glyph_row, input ready);
  modport sink   (input valid, input glyph_row, output ready);
endinterface

interface gss_out_if;
  logic           valid;
  logic           ready;
  gss_pkg::line_t upper_line;
  gss_pkg::line_t lower_line;
  logic           glyph_done;

  modport source (output valid, output upper_line, output lower_line,
                  output glyph_done, input ready);
  modport sink   (input valid, input upper_line, input lower_line,
                  input glyph_done, output ready);
endinterface

`default_nettype wire

FILE: src/gss_row_scaler.sv
// Combinational scaler: one 6-pixel row plus its neighbors above and below
// becomes two 16-pixel lines. Depends on gss_pkg.
`default_nettype none

module gss_row_scaler (
  input  wire gss_pkg::row_t   up,
  input  wire gss_pkg::row_t   cur,
  input  wire gss_pkg::row_t   down,
  input  wire logic            graphics,
  output gss_pkg::lines_t      lines
);

  logic [3:0]     c, l, u, ul, d, dl;
  logic [3:0]     top, bot;
  gss_pkg::line_t alpha_upper, alpha_lower, gfx_line;

  always_comb begin
    c  = cur[3:0];
    l  = cur[4:1];
    u  = up[3:0];
    ul = up[4:1];
    d  = down[3:0];
    dl = down[4:1];

    // A horizontal pair fills the rounding pixel on both lines; otherwise a
    // diagonal step toward the row above or below fills it on one line.
    top = (c & l) | (~c & l & u & ~ul) | (c & ~l & ~u & ul);
    bot = (c & l) | (~c & l & d & ~dl) | (c & ~l & ~d & dl);

    alpha_upper = {cur[5], cur[5], cur[4], cur[4],
                   top[3], cur[3], cur[3], top[2], cur[2], cur[2],
                   top[1], cur[1], cur[1], top[0], cur[0], cur[0]};
    alpha_lower = {cur[5], cur[5], cur[4], cur[4],
                   bot[3], cur[3], cur[3], bot[2], cur[2], cur[2],
                   bot[1], cur[1], cur[1], bot[0], cur[0], cur[0]};

    // Columns 2 and 1 overlap on one output pixel.
    gfx_line = {cur[5], cur[5], cur[4], cur[4], cur[4], cur[3], cur[3], cur[3],
                cur[2], cur[2], cur[2] | cur[1], cur[1], cur[1],
                cur[0], cur[0], cur[0]};

    if (graphics) begin
      lines.upper = gfx_line;
      lines.lower = gfx_line;
    end else begin
      lines.upper = alpha_upper;
      lines.lower = alpha_lower;
    end
  end

endmodule

`default_nettype wire

FILE: src/glyph_scale_2x2_smoothing.sv
// Glyph row scaler with character rounding: the top level.
// Depends on gss_pkg, gss_if (gss_in_if, gss_out_if) and gss_row_scaler.
//
// Usage: rows of each glyph enter top to bottom on in_ch, one transaction per
// row, GLYPH_ROWS rows per glyph. Each row leaves on out_ch as a transaction
// carrying an upper and a lower 16-pixel line. A row's lines are built once
// the row below it has arrived, so the first row of a glyph produces nothing,
// each middle row produces the lines of the row before, and the last row
// produces two transactions: the previous row and itself, the latter with
// glyph_done set. cfg_write_en / cfg_write_data set graphics_mode (1 for
// graphics widening, 0 for alpha rounding); write it only while idle.
// The result of the row before an accepted row is valid in the cycle after the
// acceptance. Rows are taken at one row per cycle while out_ch does not stall;
// the second result of a glyph's last row sits in a one-entry hold register and
// drains while the next glyph's first row, which emits nothing, is taken.
// When the receiver stalls, the output register holds its transaction and
// in_ch takes no row that would produce a result. Synchronous reset clears
// the mode, the row counter, the stored rows and both valid flags.
`default_nettype none

module glyph_scale_2x2_smoothing #(
  parameter int unsigned GLYPH_ROWS = gss_pkg::GlyphRowsDefault
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_write_en,
  input  wire logic   cfg_write_data,
  gss_in_if.sink      in_ch,
  gss_out_if.source   out_ch
);

  localparam gss_pkg::row_index_t LastRow =
    gss_pkg::RowIndexWidth'(GLYPH_ROWS - 1);

  logic                graphics_mode;
  gss_pkg::row_t       previous_row;
  gss_pkg::row_t       pending_row;
  gss_pkg::row_index_t row_index;

  logic                out_valid;
  gss_pkg::result_t    out_data;
  logic                hold_valid;
  gss_pkg::result_t    hold_data;

  logic                out_free;
  logic                in_accept;
  logic                first_row;
  logic                last_row;
  logic                emit;
  gss_pkg::lines_t     lines_prev;
  gss_pkg::lines_t     lines_last;

  gss_row_scaler u_scale_prev (
    .up       (previous_row),
    .cur      (pending_row),
    .down     (in_ch.glyph_row),
    .graphics (graphics_mode),
    .lines    (lines_prev)
  );

  // Only used on a glyph's last row: the row itself with a blank row below.
  gss_row_scaler u_scale_last (
    .up       (pending_row),
    .cur      (in_ch.glyph_row),
    .down     ('0),
    .graphics (graphics_mode),
    .lines    (lines_last)
  );

  assign out_free  = !out_valid || out_ch.ready;
  assign first_row = (row_index == '0);
  assign last_row  = (row_index == LastRow);
  // A first row only gets stored, so it is taken whatever the output holds.
  assign in_ch.ready = first_row || (out_free && !hold_valid);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign emit        = in_accept && !first_row;

  assign out_ch.valid      = out_valid;
  assign out_ch.upper_line = out_data.upper_line;
  assign out_ch.lower_line = out_data.lower_line;
  assign out_ch.glyph_done = out_data.glyph_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      graphics_mode <= 1'b0;
    end else if (cfg_write_en) begin
      graphics_mode <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_row <= '0;
      pending_row  <= '0;
      row_index    <= '0;
    end else if (in_accept) begin
      if (first_row) begin
        previous_row <= '0;
        pending_row  <= in_ch.glyph_row;
        row_index    <= gss_pkg::RowIndexWidth'(1);
      end else if (last_row) begin
        previous_row <= '0;
        pending_row  <= '0;
        row_index    <= '0;
      end else begin
        previous_row <= pending_row;
        pending_row  <= in_ch.glyph_row;
        row_index    <= row_index + gss_pkg::RowIndexWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_data   <= hold_data;
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (emit) begin
        out_data   <= '{upper_line: lines_prev.upper, lower_line: lines_prev.lower,
                        glyph_done: 1'b0};
        out_valid  <= 1'b1;
        hold_data  <= '{upper_line: lines_last.upper, lower_line: lines_last.lower,
                        glyph_done: 1'b1};
        hold_valid <= last_row;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // The hold register only fills behind a full output register.
  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("hold register valid while output register is empty");

  a_last_row_two_results: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_row) |=> (out_valid && hold_valid && hold_data.glyph_done
                                 && !out_data.glyph_done && row_index == '0))
    else $error("last row did not queue its two results");

  a_row_index_range: assert property (@(posedge clk) disable iff (rst)
    row_index <= LastRow)
    else $error("row index beyond the glyph height");

  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    (in_accept && first_row && !hold_valid && out_ch.ready) |=> !out_valid)
    else $error("first row of a glyph produced a result");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_scale_2x2_smoothing: alpha rounding, graphics widening,
// glyph framing, random traffic with gaps on both channels and a long output stall.
// Depends on gss_pkg, gss_if and the glyph scaler RTL.

module tb;

  localparam int unsigned GlyphRows = gss_pkg::GlyphRowsDefault;
  localparam int unsigned MaxPrinted = 20;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  gss_in_if  in_ch ();
  gss_out_if out_ch ();

  glyph_scale_2x2_smoothing #(
    .GLYPH_ROWS (GlyphRows)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch)
  );

  // Predictor state: the mode, the row above the held row, the held row and
  // the position of the next incoming row within its glyph.
  logic                graphics_sel;
  gss_pkg::row_t       row_above;
  gss_pkg::row_t       row_held;
  gss_pkg::row_index_t rows_into_glyph;

  gss_pkg::result_t expected_lines[$];
  gss_pkg::result_t next_expected;

  int error_count;
  int rows_sent;
  int pairs_checked;
  int glyphs_closed;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  // Returns {upper pixel, lower pixel} of the rounding pixel in front of column col.
  function automatic logic [1:0] rounding_pixel(gss_pkg::row_t above, gss_pkg::row_t cur,
                                                gss_pkg::row_t below, int col);
    logic c, l, u, ul, d, dl, top, bot;
    c   = cur[col];
    l   = cur[col+1];
    u   = above[col];
    ul  = above[col+1];
    d   = below[col];
    dl  = below[col+1];
    top = (c & l) | (~c & l & u & ~ul) | (c & ~l & ~u & ul);
    bot = (c & l) | (~c & l & d & ~dl) | (c & ~l & ~d & dl);
    return {top, bot};
  endfunction

  function automatic gss_pkg::lines_t scale_glyph_row(gss_pkg::row_t above, gss_pkg::row_t cur,
                                                      gss_pkg::row_t below, logic gfx);
    gss_pkg::lines_t res;
    logic [3:0]      tops;
    logic [3:0]      bots;
    logic [1:0]      tb_pair;
    if (gfx) begin
      // Columns 2 and 1 overlap on bit 5.
      res.upper = {{2{cur[5]}}, {3{cur[4]}}, {3{cur[3]}}, {2{cur[2]}}, cur[2] | cur[1],
                   {2{cur[1]}}, {3{cur[0]}}};
      res.lower = res.upper;
    end else begin
      for (int col = 0; col < 4; col++) begin
        tb_pair   = rounding_pixel(above, cur, below, col);
        tops[col] = tb_pair[1];
        bots[col] = tb_pair[0];
      end
      res.upper = {{2{cur[5]}}, {2{cur[4]}}, tops[3], {2{cur[3]}}, tops[2], {2{cur[2]}},
                   tops[1], {2{cur[1]}}, tops[0], {2{cur[0]}}};
      res.lower = {{2{cur[5]}}, {2{cur[4]}}, bots[3], {2{cur[3]}}, bots[2], {2{cur[2]}},
                   bots[1], {2{cur[1]}}, bots[0], {2{cur[0]}}};
    end
    return res;
  endfunction

  function automatic void push_lines(gss_pkg::lines_t pair, logic done);
    gss_pkg::result_t res;
    res.upper_line = pair.upper;
    res.lower_line = pair.lower;
    res.glyph_done = done;
    expected_lines.push_back(res);
  endfunction

  function automatic void predict_scaled_lines(gss_pkg::row_t row);
    if (rows_into_glyph == 0) begin
      row_above       = '0;
      row_held        = row;
      rows_into_glyph = gss_pkg::row_index_t'(1);
    end else begin
      push_lines(scale_glyph_row(row_above, row_held, row, graphics_sel), 1'b0);
      row_above = row_held;
      row_held  = row;
      if (rows_into_glyph >= GlyphRows - 1) begin
        // The last row goes out at once with a blank row below it.
        push_lines(scale_glyph_row(row_above, row_held, '0, graphics_sel), 1'b1);
        row_above       = '0;
        row_held        = '0;
        rows_into_glyph = '0;
        glyphs_closed++;
      end else begin
        rows_into_glyph = rows_into_glyph + 1'b1;
      end
    end
  endfunction

  // Receiver: random ready, or a counted hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ch.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction upper=%h lower=%h done=%b",
                                  out_ch.upper_line, out_ch.lower_line, out_ch.glyph_done));
      end else begin
        next_expected = expected_lines.pop_front();
        if (out_ch.upper_line !== next_expected.upper_line)
          report_mismatch($sformatf("upper_line %h, expected %h",
                                    out_ch.upper_line, next_expected.upper_line));
        if (out_ch.lower_line !== next_expected.lower_line)
          report_mismatch($sformatf("lower_line %h, expected %h",
                                    out_ch.lower_line, next_expected.lower_line));
        if (out_ch.glyph_done !== next_expected.glyph_done)
          report_mismatch($sformatf("glyph_done %b, expected %b",
                                    out_ch.glyph_done, next_expected.glyph_done));
        pairs_checked++;
      end
    end
  end

  task automatic send_row(input gss_pkg::row_t row);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.glyph_row <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_scaled_lines(row);
    rows_sent++;
  endtask

  // Drops valid and waits until every predicted line pair has been checked.
  task automatic drain_outputs();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic gfx);
    drain_outputs();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= gfx;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    graphics_sel = gfx;
  endtask

  // Sparse shapes in half of the draws so that the diagonal rounding rules fire often.
  function automatic gss_pkg::row_t random_row();
    case ($urandom_range(3))
      0: return gss_pkg::row_t'(1 << $urandom_range(5));
      1: return gss_pkg::row_t'(3 << $urandom_range(4));
      default: return gss_pkg::row_t'($urandom_range(63));
    endcase
  endfunction

  task automatic test_alpha_rounding();
    gss_pkg::row_t rows[10];
    write_mode(1'b0);
    // A rising diagonal, a full row, a blank row and alternating pixels,
    // ending with a last row that sees a blank row below.
    rows = '{6'b000001, 6'b000010, 6'b000100, 6'b001000, 6'b010000,
             6'b100000, 6'b111111, 6'b000000, 6'b101010, 6'b010101};
    foreach (rows[i]) send_row(rows[i]);
  endtask

  task automatic test_graphics_widening();
    gss_pkg::row_t rows[7];
    // Three rows in alpha mode, then the mode flips inside the glyph.
    send_row(6'b111111);
    send_row(6'b011000);
    send_row(6'b000110);
    write_mode(1'b1);
    rows = '{6'b000110, 6'b000100, 6'b000010, 6'b100000, 6'b010000, 6'b000001, 6'b111111};
    foreach (rows[i]) send_row(rows[i]);
  endtask

  task automatic test_random_rows(input int count, input int tx_pct, input int rx_pct,
                                  input logic gfx);
    write_mode(gfx);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_row(random_row());
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    write_mode(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(posedge clk);
    rx_hold_cycles = 80;
    repeat (40) send_row(random_row());
  endtask

  initial begin
    rst             = 1'b1;
    cfg_write_en    = 1'b0;
    cfg_write_data  = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.glyph_row = '0;
    graphics_sel    = 1'b0;
    row_above       = '0;
    row_held        = '0;
    rows_into_glyph = '0;
    error_count     = 0;
    rows_sent       = 0;
    pairs_checked   = 0;
    glyphs_closed   = 0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    rx_hold_cycles  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_alpha_rounding();
    test_graphics_widening();
    test_random_rows(337, 11, 57, 1'b0);
    test_random_rows(341, 57, 11, 1'b1);
    test_output_backpressure();
    test_random_rows(171, 0, 0, 1'b1);
    test_random_rows(167, 0, 0, 1'b0);

    drain_outputs();
    repeat (20) @(posedge clk);
    $display("Covered %0d rows in %0d complete glyphs, %0d line pairs checked,",
             rows_sent, glyphs_closed, pairs_checked);
    $display("in both modes with mode changes mid-glyph, idle gaps and a long output stall.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: the run did not complete, %0d line pairs still outstanding.",
             expected_lines.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: glyph_scale_2x2_smoothing.f
src/gss_pkg.sv
src/gss_if.sv
src/gss_row_scaler.sv
src/glyph_scale_2x2_smoothing.sv
sim/tb.sv
